// File: hw/rtl/bdeq_pkg.sv
package bdeq_pkg;

    // Request commands
    localparam logic [2:0] CMD_LIST       = 3'd0;
    localparam logic [2:0] CMD_PUSH_FRONT = 3'd1;
    localparam logic [2:0] CMD_PUSH_BACK  = 3'd2;
    localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
    localparam logic [2:0] CMD_POP_BACK   = 3'd4;

    // Result status
    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_EMPTY = 2'd1;
    localparam logic [1:0] STAT_FULL  = 2'd2;

    // Stream field layout
    localparam int CMD_W     = 3;
    localparam int VALUE_W   = 32;
    localparam int ELEM_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int FILL_W    = 5;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 40;

    // Cell operations, broadcast along the chain
    typedef logic [2:0] t_cell_op;
    localparam t_cell_op OP_HOLD       = 3'd0;
    localparam t_cell_op OP_SHIFT_IN   = 3'd1; // take left neighbor (front insert)
    localparam t_cell_op OP_LOAD_FREE  = 3'd2; // first free cell takes the value
    localparam t_cell_op OP_SHIFT_OUT  = 3'd3; // take right neighbor (front remove)
    localparam t_cell_op OP_ROTATE     = 3'd4; // tail takes head, rest shift left

    typedef struct packed {
        t_cell_op op;
        logic     at_tail;
        logic     at_free;
    } t_cell_ctrl;

endpackage

// File: hw/rtl/bdeq_cell.sv
module bdeq_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                      i_clk,
    input  bdeq_pkg::t_cell_ctrl      i_ctrl,
    input  logic [DATA_WIDTH-1:0]     i_from_prev,
    input  logic [DATA_WIDTH-1:0]     i_from_next,
    input  logic [DATA_WIDTH-1:0]     i_head,
    input  logic [DATA_WIDTH-1:0]     i_value,
    output logic [DATA_WIDTH-1:0]     o_data
);

    logic [DATA_WIDTH-1:0] r_data;
    logic [DATA_WIDTH-1:0] n_data;

    always_comb begin
        n_data = r_data;
        case (i_ctrl.op)
            bdeq_pkg::OP_SHIFT_IN:  n_data = i_from_prev;
            bdeq_pkg::OP_LOAD_FREE: begin
                if (i_ctrl.at_free) begin
                    n_data = i_value;
                end
            end
            bdeq_pkg::OP_SHIFT_OUT: n_data = i_from_next;
            bdeq_pkg::OP_ROTATE:    n_data = i_ctrl.at_tail ? i_head : i_from_next;
            default:                n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// File: hw/rtl/bounded_deque_engine_core.sv
// Bounded double-ended queue of signed values held in a row of DEPTH cells; the
// front element always sits in the first cell. Push front shifts the row one cell
// back, pop front shifts it one cell forward, push back writes the first free cell
// and pop back reads the tail cell. Push and pop requests each give one result. A
// list request gives one result per stored element, one a cycle while the output
// is taken, by rotating the row one cell per result, so it holds the input until
// the last element has been given; a list of an empty store gives a single empty
// result. Results sit in an output register, and a new request is taken only when
// that register is empty or its result is taken in the same cycle. Unknown
// commands are consumed and give no result.
module bounded_deque_engine_core #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [2:0] command, [34:3] value, rest zero
    input  logic [bdeq_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [31:0] element, [36:32] fill_count, rest zero
    output logic [bdeq_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // [1:0] status
    output logic [bdeq_pkg::STATUS_W-1:0]  m_axis_tuser,
    output logic                           m_axis_tlast
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LIST = 1'b1;

    logic                           r_state, n_state;
    logic [CW-1:0]                  r_count, n_count;
    logic [CW-1:0]                  r_list_idx, n_list_idx;
    logic                           r_out_valid, n_out_valid;
    logic [bdeq_pkg::ELEM_W-1:0]    r_out_elem, n_out_elem;
    logic [bdeq_pkg::STATUS_W-1:0]  r_out_status, n_out_status;
    logic                           r_out_last, n_out_last;
    logic [bdeq_pkg::FILL_W-1:0]    r_out_fill, n_out_fill;

    logic [bdeq_pkg::CMD_W-1:0]     w_cmd;
    logic [bdeq_pkg::VALUE_W-1:0]   w_value_in;
    logic [DATA_WIDTH-1:0]          w_value;
    logic [DATA_WIDTH-1:0]          w_data [DEPTH];
    logic [DATA_WIDTH-1:0]          w_tail_data;
    logic [DATA_WIDTH-1:0]          w_pick;
    logic [bdeq_pkg::ELEM_W-1:0]    w_pick_ext;
    bdeq_pkg::t_cell_op             w_op;
    bdeq_pkg::t_cell_ctrl           w_ctrl [DEPTH];
    logic                           w_out_free;
    logic                           w_in_fire;
    logic                           w_empty;
    logic [CW-1:0]                  w_tail_idx;

    assign w_cmd      = s_axis_tdata[bdeq_pkg::CMD_W-1:0];
    assign w_value_in = s_axis_tdata[bdeq_pkg::CMD_W +: bdeq_pkg::VALUE_W];
    assign w_empty    = (r_count == '0);
    assign w_tail_idx = r_count - CW'(1);
    assign w_out_free = !r_out_valid || m_axis_tready;

    assign s_axis_tready = (r_state == ST_IDLE) && w_out_free;
    assign w_in_fire     = s_axis_tvalid && s_axis_tready;

    // Width adaptation between the 32-bit stream fields and the stored width
    generate
        if (DATA_WIDTH > 32) begin : g_wide
            assign w_value    = {{(DATA_WIDTH-32){w_value_in[31]}}, w_value_in};
            assign w_pick_ext = w_pick[31:0];
        end else if (DATA_WIDTH == 32) begin : g_same
            assign w_value    = w_value_in;
            assign w_pick_ext = w_pick;
        end else begin : g_narrow
            assign w_value    = w_value_in[DATA_WIDTH-1:0];
            assign w_pick_ext = {{(32-DATA_WIDTH){w_pick[DATA_WIDTH-1]}}, w_pick};
        end
    endgenerate

    // Cell chain
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic [DATA_WIDTH-1:0] w_prev;
            logic [DATA_WIDTH-1:0] w_next;

            if (g == 0) begin : g_first
                assign w_prev = w_value;
            end else begin : g_mid
                assign w_prev = w_data[g-1];
            end
            if (g == DEPTH - 1) begin : g_last
                assign w_next = w_data[g];
            end else begin : g_inner
                assign w_next = w_data[g+1];
            end

            assign w_ctrl[g].op      = w_op;
            assign w_ctrl[g].at_tail = !w_empty && (w_tail_idx == CW'(g));
            assign w_ctrl[g].at_free = (r_count == CW'(g));

            bdeq_cell #(
                .DATA_WIDTH(DATA_WIDTH)
            ) u_cell (
                .i_clk       (i_clk),
                .i_ctrl      (w_ctrl[g]),
                .i_from_prev (w_prev),
                .i_from_next (w_next),
                .i_head      (w_data[0]),
                .i_value     (w_value),
                .o_data      (w_data[g])
            );
        end
    endgenerate

    always_comb begin
        w_tail_data = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (w_ctrl[i].at_tail) begin
                w_tail_data = w_tail_data | w_data[i];
            end
        end
    end

    assign w_pick = (r_state == ST_IDLE && w_cmd == bdeq_pkg::CMD_POP_BACK)
                    ? w_tail_data : w_data[0];

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_list_idx   = r_list_idx;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_elem   = r_out_elem;
        n_out_status = r_out_status;
        n_out_last   = r_out_last;
        n_out_fill   = r_out_fill;
        w_op         = bdeq_pkg::OP_HOLD;

        if (r_state == ST_LIST) begin
            if (w_out_free) begin
                w_op         = bdeq_pkg::OP_ROTATE;
                n_out_valid  = 1'b1;
                n_out_elem   = w_pick_ext;
                n_out_status = bdeq_pkg::STAT_OK;
                n_out_last   = (r_list_idx == w_tail_idx);
                n_out_fill   = bdeq_pkg::FILL_W'(r_count);
                n_list_idx   = r_list_idx + CW'(1);
                if (r_list_idx == w_tail_idx) begin
                    n_state = ST_IDLE;
                end
            end
        end else if (w_in_fire) begin
            case (w_cmd)
                bdeq_pkg::CMD_LIST: begin
                    if (w_empty) begin
                        n_out_valid  = 1'b1;
                        n_out_elem   = '0;
                        n_out_status = bdeq_pkg::STAT_EMPTY;
                        n_out_last   = 1'b1;
                        n_out_fill   = bdeq_pkg::FILL_W'(r_count);
                    end else begin
                        n_state    = ST_LIST;
                        n_list_idx = '0;
                    end
                end
                bdeq_pkg::CMD_PUSH_FRONT, bdeq_pkg::CMD_PUSH_BACK: begin
                    n_out_valid = 1'b1;
                    n_out_elem  = '0;
                    n_out_last  = 1'b1;
                    if (r_count == FULL_COUNT) begin
                        n_out_status = bdeq_pkg::STAT_FULL;
                    end else begin
                        w_op         = (w_cmd == bdeq_pkg::CMD_PUSH_FRONT)
                                       ? bdeq_pkg::OP_SHIFT_IN : bdeq_pkg::OP_LOAD_FREE;
                        n_count      = r_count + CW'(1);
                        n_out_status = bdeq_pkg::STAT_OK;
                    end
                    n_out_fill = bdeq_pkg::FILL_W'(n_count);
                end
                bdeq_pkg::CMD_POP_FRONT, bdeq_pkg::CMD_POP_BACK: begin
                    n_out_valid = 1'b1;
                    n_out_last  = 1'b1;
                    if (w_empty) begin
                        n_out_elem   = '0;
                        n_out_status = bdeq_pkg::STAT_EMPTY;
                    end else begin
                        if (w_cmd == bdeq_pkg::CMD_POP_FRONT) begin
                            w_op = bdeq_pkg::OP_SHIFT_OUT;
                        end
                        n_count      = r_count - CW'(1);
                        n_out_elem   = w_pick_ext;
                        n_out_status = bdeq_pkg::STAT_OK;
                    end
                    n_out_fill = bdeq_pkg::FILL_W'(n_count);
                end
                default: begin
                    n_state = r_state;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_list_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_list_idx  <= n_list_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_elem   <= n_out_elem;
        r_out_status <= n_out_status;
        r_out_last   <= n_out_last;
        r_out_fill   <= n_out_fill;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {
        (bdeq_pkg::M_TDATA_W - bdeq_pkg::ELEM_W - bdeq_pkg::FILL_W)'(0),
        r_out_fill,
        r_out_elem
    };
    assign m_axis_tuser  = r_out_status;
    assign m_axis_tlast  = r_out_last;

endmodule
